// File: hw/rtl/channel_busy_table_reserve_assert.svh
// Assertion macros for the channel busy table.
// Depends on nothing; taken in by the modules that assert.
`ifndef CHANNEL_BUSY_TABLE_RESERVE_ASSERT_SVH
`define CHANNEL_BUSY_TABLE_RESERVE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CBT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/cbt_pkg.sv
// Shared types and codes of the channel busy table.
// Depends on nothing.
package cbt_pkg;

   // Commands
   localparam logic [1:0] CMD_CHECK   = 2'd0;
   localparam logic [1:0] CMD_RESERVE = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_BACKWARD = 2'd0;
   localparam logic [1:0] REG_QPC      = 2'd1;
   localparam logic [1:0] REG_CHANS    = 2'd2;
   localparam logic [1:0] REG_CORES    = 2'd3;

   typedef struct packed {
      logic       backward_mode;
      logic [6:0] qubits_per_core;
      logic [3:0] channels_in_use;
      logic [2:0] core_count;
   } cfg_type;

   // Classified item passed from front to back
   typedef struct packed {
      logic [1:0]      command;
      logic [31:0]     launch_cycle;
      logic [15:0]     duration_cycles;
      logic            is_inter_core;
      logic [1:0]      operand_count;
      logic [1:0][7:0] core;
   } item_type;

endpackage

// File: hw/rtl/cbt_channels.sv
// Channel interfaces of the channel busy table: request and response.
// Depends on nothing.
interface cbt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] launch_cycle;
   logic [15:0] duration_cycles;
   logic        is_inter_core;
   logic [1:0]  operand_count;
   logic [7:0]  qubit_first;
   logic [7:0]  qubit_second;

   modport source (output valid, command, launch_cycle, duration_cycles, is_inter_core,
                   operand_count, qubit_first, qubit_second, input ready);
   modport sink   (input valid, command, launch_cycle, duration_cycles, is_inter_core,
                   operand_count, qubit_first, qubit_second, output ready);
endinterface

interface cbt_rsp_if;
   logic valid;
   logic ready;
   logic is_available;
   logic reserve_failed;

   modport source (output valid, is_available, reserve_failed, input ready);
   modport sink   (input valid, is_available, reserve_failed, output ready);
endinterface

// File: hw/rtl/channel_busy_table_reserve.sv
// Top level of the channel busy table: configuration registers, front end,
// item queue and back end. Depends on cbt_pkg, cbt_channels and the submodules.
//
// Use: a scheduler sends request items on req (check, reserve or clear) and
// takes one response item per request on rsp (is_available, reserve_failed).
// Configuration sits behind the APB-style csr_ port: backward_mode at 0x0,
// qubits_per_core at 0x4, channels_in_use at 0x8, core_count at 0xC; write
// these only while no item is in flight.
// The front end accepts an item and runs a pair of two-bit-per-cycle restoring
// dividers for the operands' cores, then pushes the item into a two-entry
// queue; the back end pops it, handles an inter-core check or reserve one
// operand per cycle on the row search and update, and registers the response.
// The front end takes no new item until it has pushed the last one.
// Reset empties the queue, drops any response and fills the table with zero;
// registers return to 0, 8, 8, 1.
// When rsp stalls the response register holds; the queue keeps taking items
// until full, after which req.ready stays low.
module channel_busy_table_reserve #(
   parameter int MAX_CORES    = 4,
   parameter int MAX_CHANNELS = 8,
   parameter int MAX_OPERANDS = 2,
   parameter int CYCLE_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   cbt_req_if.sink     req,
   cbt_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import cbt_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     csr_wr;
   logic     push_valid, push_ready, pop_valid, pop_ready;
   item_type push_data, pop_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_BACKWARD: cfg_in.backward_mode   = csr_pwdata[0];
            REG_QPC:      cfg_in.qubits_per_core = csr_pwdata[6:0];
            REG_CHANS:    cfg_in.channels_in_use = csr_pwdata[3:0];
            REG_CORES:    cfg_in.core_count      = csr_pwdata[2:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // Register read-back
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_BACKWARD: csr_prdata = {31'd0, cfg_ff.backward_mode};
         REG_QPC:      csr_prdata = {25'd0, cfg_ff.qubits_per_core};
         REG_CHANS:    csr_prdata = {28'd0, cfg_ff.channels_in_use};
         REG_CORES:    csr_prdata = {29'd0, cfg_ff.core_count};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.backward_mode   <= 1'b0;
         cfg_ff.qubits_per_core <= 7'd8;
         cfg_ff.channels_in_use <= 4'd8;
         cfg_ff.core_count      <= 3'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   cbt_queue #(
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cbt_back #(
      .MAX_CORES    (MAX_CORES),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_OPERANDS (MAX_OPERANDS),
      .CYCLE_BITS   (CYCLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp)
   );

endmodule

// File: hw/rtl/cbt_front.sv
// Front end: accepts request items and works out each operand's core.
// Depends on cbt_pkg and the request interface.
module cbt_front (
   input  logic              clock,
   input  logic              reset,
   input  cbt_pkg::cfg_type  cfg,
   cbt_req_if.sink           req,
   output logic              push_valid,
   input  logic              push_ready,
   output cbt_pkg::item_type push_data
);
   import cbt_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [1:0]  step_ff, step_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [31:0] start_ff, start_in;
   logic [15:0] dur_ff, dur_in;
   logic        inter_ff, inter_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [1:0][7:0] dvd_ff, dvd_in;
   logic [1:0][7:0] quo_ff, quo_in;
   logic [1:0][6:0] rem_ff, rem_in;
   logic [6:0]  divisor;

   // One restoring divide step: returns quotient bit and new remainder
   function automatic logic [7:0] div_step(input logic [6:0] rem, input logic bit_in,
                                           input logic [6:0] d);
      logic [7:0] t;
      logic [7:0] r;
      t = {rem, bit_in};
      if (t >= {1'b0, d}) begin
         r = t - {1'b0, d};
         return {1'b1, r[6:0]};
      end
      return {1'b0, t[6:0]};
   endfunction

   assign divisor   = (cfg.qubits_per_core == 7'd0) ? 7'd1 : cfg.qubits_per_core;
   assign req.ready = (state_ff == F_IDLE);

   // Sequence accept, divide and push
   always_comb begin
      logic [7:0] s1;
      logic [7:0] s2;
      state_in = state_ff;
      step_in  = step_ff;
      cmd_in   = cmd_ff;
      start_in = start_ff;
      dur_in   = dur_ff;
      inter_in = inter_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      s1 = 8'd0;
      s2 = 8'd0;
      unique case (state_ff)
         F_IDLE: begin
            if (req.valid) begin
               cmd_in    = req.command;
               start_in  = req.launch_cycle;
               dur_in    = req.duration_cycles;
               inter_in  = req.is_inter_core;
               cnt_in    = req.operand_count;
               dvd_in[0] = req.qubit_first;
               dvd_in[1] = req.qubit_second;
               rem_in    = '0;
               quo_in    = '0;
               step_in   = 2'd0;
               state_in  = F_DIV;
            end
         end
         F_DIV: begin
            // Two quotient bits per cycle for both operands
            for (int k = 0; k < 2; k++) begin
               s1 = div_step(rem_ff[k], dvd_ff[k][7], divisor);
               s2 = div_step(s1[6:0], dvd_ff[k][6], divisor);
               rem_in[k] = s2[6:0];
               quo_in[k] = {quo_ff[k][5:0], s1[7], s2[7]};
               dvd_in[k] = {dvd_ff[k][5:0], 2'b00};
            end
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign push_valid                = (state_ff == F_PUSH);
   assign push_data.command         = cmd_ff;
   assign push_data.launch_cycle    = start_ff;
   assign push_data.duration_cycles = dur_ff;
   assign push_data.is_inter_core   = inter_ff;
   assign push_data.operand_count   = cnt_ff;
   assign push_data.core            = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      cmd_ff   <= cmd_in;
      start_ff <= start_in;
      dur_ff   <= dur_in;
      inter_ff <= inter_in;
      cnt_ff   <= cnt_in;
      dvd_ff   <= dvd_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
   end

endmodule

// File: hw/rtl/cbt_queue.sv
// Short item queue between front and back end.
// Depends on cbt_pkg.
module cbt_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  cbt_pkg::item_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output cbt_pkg::item_type pop_data
);
   import cbt_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        slot_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign push_ready = (cnt_ff != CW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/cbt_back.sv
// Back end: holds the boundary table, searches and reserves channels,
// and drives the response register. Depends on cbt_pkg, the response
// interface and the assertion macros.
`include "channel_busy_table_reserve_assert.svh"

module cbt_back #(
   parameter int MAX_CORES    = 4,
   parameter int MAX_CHANNELS = 8,
   parameter int MAX_OPERANDS = 2,
   parameter int CYCLE_BITS   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  cbt_pkg::cfg_type  cfg,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  cbt_pkg::item_type pop_data,
   cbt_rsp_if.source         rsp
);
   import cbt_pkg::*;

   localparam int CORE_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int EW     = (CYCLE_BITS > 33) ? CYCLE_BITS : 33;
   localparam int OP_LIM = (MAX_OPERANDS < 2) ? MAX_OPERANDS : 2;

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_OP   = 2'b10
   } back_state_type;

   back_state_type  state_ff, state_in;
   item_type        item_ff, item_in;
   logic            op_ff, op_in;
   logic            avail_ff, avail_in;
   logic            fail_ff, fail_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_avail_ff, rsp_avail_in;
   logic            rsp_fail_ff, rsp_fail_in;
   logic [CYCLE_BITS-1:0] tbl_ff [MAX_CORES][MAX_CHANNELS];

   logic [1:0]        cnt_cap;
   logic [4:0]        core_lim;
   logic [5:0]        chan_lim;
   logic [7:0]        core_q;
   logic              core_ok;
   logic [CORE_W-1:0] core_idx;
   logic [EW-1:0]     start_x, end_x, new_x;
   logic [CYCLE_BITS-1:0] new_val;
   logic [MAX_CHANNELS-1:0] ch_free;
   logic              found;
   logic [CH_W-1:0]   ch_sel;
   logic              do_clear, do_write;
   logic              last_op;

   // Limits from configuration
   always_comb begin
      cnt_cap  = (item_ff.operand_count > 2'(OP_LIM)) ? 2'(OP_LIM) : item_ff.operand_count;
      core_lim = ({2'b00, cfg.core_count} > 5'(MAX_CORES)) ? 5'(MAX_CORES)
                                                            : {2'b00, cfg.core_count};
      chan_lim = ({2'b00, cfg.channels_in_use} > 6'(MAX_CHANNELS)) ? 6'(MAX_CHANNELS)
                                                                   : {2'b00, cfg.channels_in_use};
   end

   // Search the row of the current operand's core
   always_comb begin
      core_q   = item_ff.core[op_ff];
      core_ok  = ({3'b000, core_lim} > core_q);
      core_idx = core_q[CORE_W-1:0];
      start_x  = EW'(item_ff.launch_cycle);
      end_x    = EW'(item_ff.launch_cycle) + EW'(item_ff.duration_cycles);
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         ch_free[c] = core_ok && (6'(c) < chan_lim) &&
                      (cfg.backward_mode ? (end_x <= EW'(tbl_ff[core_idx][c]))
                                         : (start_x >= EW'(tbl_ff[core_idx][c])));
      end
      found  = 1'b0;
      ch_sel = '0;
      for (int c = MAX_CHANNELS - 1; c >= 0; c--) begin
         if (ch_free[c]) begin
            found  = 1'b1;
            ch_sel = CH_W'(c);
         end
      end
      new_x   = cfg.backward_mode ? start_x : end_x;
      new_val = (new_x > EW'({CYCLE_BITS{1'b1}})) ? {CYCLE_BITS{1'b1}}
                                                  : new_x[CYCLE_BITS-1:0];
      last_op = op_ff || (cnt_cap == 2'd1);
   end

   assign pop_ready = (state_ff == B_IDLE) && !rsp_valid_ff;

   // Sequence items one operand per cycle
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      op_in        = op_ff;
      avail_in     = avail_ff;
      fail_in      = fail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_avail_in = rsp_avail_ff;
      rsp_fail_in  = rsp_fail_ff;
      do_clear     = 1'b0;
      do_write     = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid && pop_ready) begin
               item_in = pop_data;
               case (pop_data.command)
                  CMD_CLEAR: begin
                     do_clear     = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_avail_in = 1'b0;
                     rsp_fail_in  = 1'b0;
                  end
                  CMD_UNUSED: begin
                     rsp_valid_in = 1'b1;
                     rsp_avail_in = 1'b0;
                     rsp_fail_in  = 1'b0;
                  end
                  default: begin
                     if (!pop_data.is_inter_core || pop_data.operand_count == 2'd0 ||
                         OP_LIM == 0) begin
                        rsp_valid_in = 1'b1;
                        rsp_avail_in = 1'b1;
                        rsp_fail_in  = 1'b0;
                     end else begin
                        op_in    = 1'b0;
                        avail_in = 1'b1;
                        fail_in  = 1'b0;
                        state_in = B_OP;
                     end
                  end
               endcase
            end
         end
         B_OP: begin
            if (!found) begin
               avail_in = 1'b0;
               fail_in  = fail_ff || (item_ff.command == CMD_RESERVE);
            end else if (item_ff.command == CMD_RESERVE) begin
               do_write = 1'b1;
            end
            if (last_op) begin
               rsp_valid_in = 1'b1;
               rsp_avail_in = avail_in;
               rsp_fail_in  = fail_in;
               state_in     = B_IDLE;
            end else begin
               op_in = 1'b1;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.is_available   = rsp_avail_ff;
   assign rsp.reserve_failed = rsp_fail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      op_ff        <= op_in;
      avail_ff     <= avail_in;
      fail_ff      <= fail_in;
      rsp_avail_ff <= rsp_avail_in;
      rsp_fail_ff  <= rsp_fail_in;
   end

   // Boundary table: fill on reset or clear, update the chosen channel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CORES; i++) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
               tbl_ff[i][c] <= '0;
            end
         end
      end else if (do_clear) begin
         for (int i = 0; i < MAX_CORES; i++) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
               tbl_ff[i][c] <= cfg.backward_mode ? {CYCLE_BITS{1'b1}} : '0;
            end
         end
      end else if (do_write) begin
         tbl_ff[core_idx][ch_sel] <= new_val;
      end
   end

   `CBT_ASSERT_NOW(a_op_no_pending_rsp, clock, reset, state_ff == B_OP, !rsp_valid_ff,
      "operand work started while a response was pending")
   `CBT_ASSERT_NOW(a_fail_not_avail, clock, reset, rsp_valid_ff && rsp_fail_ff,
      !rsp_avail_ff, "failed reserve reported as available")
   `CBT_ASSERT_NOW(a_second_op_count, clock, reset, state_ff == B_OP && op_ff,
      cnt_cap == 2'd2, "second operand handled for a single-operand item")
   `CBT_ASSERT_NEXT(a_clear_fills, clock, reset, do_clear,
      tbl_ff[0][0] == ($past(cfg.backward_mode) ? {CYCLE_BITS{1'b1}} : '0),
      "table not filled by clear")

endmodule
